// ----- hdl/kcr_pkg.sv -----
// ----------------------------------------------------------------------------
// kcr_pkg
// Shared constants, codes and control types for the replicate-border
// convolution core.
// ----------------------------------------------------------------------------
`default_nettype none

package kcr_pkg;

    // default sizing of the core
    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_KERNEL_W   = 15;
    localparam int DEF_MAX_KERNEL_H   = 11;
    localparam int DEF_COEF_FRAC_BITS = 14;

    // frame height limit and the row counter that covers it
    localparam int MAX_HEIGHT = 2048;
    localparam int ROW_W      = 11;

    // field widths
    localparam int CFG_W   = 12;
    localparam int KCFG_W  = 4;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int CIDX_W  = 8;
    localparam int OP_W    = 2;
    localparam int CFGIX_W = 2;

    // register reset values
    localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [KCFG_W-1:0] RST_KERNEL_WIDTH  = 4'd9;
    localparam logic [KCFG_W-1:0] RST_KERNEL_HEIGHT = 4'd9;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] ALPHA   = 8'hFF;

    // register indexes
    localparam logic [CFGIX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFGIX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFGIX_W-1:0] REG_KERNEL_WIDTH  = 2'd2;
    localparam logic [CFGIX_W-1:0] REG_KERNEL_HEIGHT = 2'd3;

    // request operation codes
    localparam logic [OP_W-1:0] OP_COEF  = 2'd0;
    localparam logic [OP_W-1:0] OP_PIX   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_coef;
        logic store_pix;
        logic acc_clear;
        logic tap_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic tap_last;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/kcr_if.sv -----
// ----------------------------------------------------------------------------
// kcr_if
// Valid/ready channels for requests into and results out of the core.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  coef_index;
    logic [15:0] coef_value;
    logic [7:0]  pix_c0;
    logic [7:0]  pix_c1;
    logic [7:0]  pix_c2;

    modport source (output valid, op, coef_index, coef_value, pix_c0, pix_c1, pix_c2,
                    input ready);
    modport sink (input valid, op, coef_index, coef_value, pix_c0, pix_c1, pix_c2,
                  output ready);
endinterface

interface kcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic [7:0] out_alpha;
    logic       last_of_frame;

    modport source (output valid, out_c0, out_c1, out_c2, out_alpha, last_of_frame,
                    input ready);
    modport sink (input valid, out_c0, out_c1, out_c2, out_alpha, last_of_frame,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/kcr_datapath.sv -----
// ----------------------------------------------------------------------------
// kcr_datapath
// Config registers, line ring, kernel table, frame counters, tap walk,
// per-channel multiply-accumulate and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcr_datapath #(
    parameter int MAX_WIDTH      = kcr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL_W   = kcr_pkg::DEF_MAX_KERNEL_W,
    parameter int MAX_KERNEL_H   = kcr_pkg::DEF_MAX_KERNEL_H,
    parameter int COEF_FRAC_BITS = kcr_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [kcr_pkg::CFGIX_W-1:0]   cfg_index,
    input  wire logic [kcr_pkg::CFG_W-1:0]     cfg_data,
    input  wire kcr_pkg::cmd_t                 cmd,
    output kcr_pkg::status_t                   status,
    input  wire logic [kcr_pkg::CIDX_W-1:0]    coef_index,
    input  wire logic [kcr_pkg::COEF_W-1:0]    coef_value,
    input  wire logic [kcr_pkg::PIX_W-1:0]     pix_c0,
    input  wire logic [kcr_pkg::PIX_W-1:0]     pix_c1,
    input  wire logic [kcr_pkg::PIX_W-1:0]     pix_c2,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [kcr_pkg::PIX_W-1:0]          out_c0,
    output logic [kcr_pkg::PIX_W-1:0]          out_c1,
    output logic [kcr_pkg::PIX_W-1:0]          out_c2,
    output logic                               out_last
);
    import kcr_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = CW + 1;
    localparam int KWW    = $clog2(MAX_KERNEL_W + 1);
    localparam int KHW    = $clog2(MAX_KERNEL_H + 1);
    localparam int RING   = MAX_KERNEL_H + MAX_KERNEL_W / 2 + 2;
    localparam int SW     = $clog2(RING);
    localparam int LDEPTH = RING * MAX_WIDTH;
    localparam int AW     = $clog2(LDEPTH);
    localparam int CDEPTH = MAX_KERNEL_W * MAX_KERNEL_H;
    localparam int CIW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int TW     = WW + CFG_W;
    localparam int ACW    = PIX_W + COEF_W + $clog2(CDEPTH + 1);
    localparam int PW     = PIX_W + COEF_W;
    localparam int RSW    = ROW_W + 2;
    localparam int CSW    = CW + KWW + 2;
    localparam int OSW    = SW + 2;

    // saturate a shifted sum to a pixel value
    function automatic logic [PIX_W-1:0] sat_pix(input logic [ACW-1:0] acc);
        logic [ACW-1:0] v;
        v = acc >> COEF_FRAC_BITS;
        if (v > ACW'(PIX_MAX))
            return PIX_MAX;
        else
            return v[PIX_W-1:0];
    endfunction

    // storage
    logic [3*PIX_W-1:0]  line_mem [LDEPTH];
    logic [COEF_W-1:0]   coef_mem [CDEPTH];

    // config registers
    logic [CFG_W-1:0]  image_width_reg, image_height_reg;
    logic [KCFG_W-1:0] kernel_width_reg, kernel_height_reg;

    // frame state
    logic [TW-1:0]    in_cnt_reg, out_cnt_reg;
    logic [CW-1:0]    in_col_reg, out_col_reg;
    logic [SW-1:0]    in_slot_reg, out_slot_reg;
    logic [ROW_W-1:0] out_row_reg;

    // tap walk
    logic [KWW-1:0]   tap_x_reg;
    logic [KHW-1:0]   tap_y_reg;
    logic [CIW-1:0]   coef_idx_reg;

    // pipeline
    logic               rd_valid_reg, prod_valid_reg;
    logic [3*PIX_W-1:0] rd_pix_reg;
    logic [COEF_W-1:0]  rd_coef_reg;
    logic [PW-1:0]      prod0_reg, prod1_reg, prod2_reg;
    logic [ACW-1:0]     acc0_reg, acc1_reg, acc2_reg;

    // output register
    logic             out_valid_reg, out_last_reg;
    logic [PIX_W-1:0] out_c0_reg, out_c1_reg, out_c2_reg;

    // effective sizes
    logic [WW-1:0]    w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [KWW-1:0]   kw_eff, kw_half;
    logic [KHW-1:0]   kh_eff, kh_half;
    logic [TW-1:0]    total, lag;
    logic [TW:0]      ahead;
    logic             can_store, frame_done;

    // read address
    logic signed [RSW-1:0] row_s;
    logic [ROW_W-1:0]      src_row;
    logic signed [RSW-1:0] row_off;
    logic signed [OSW-1:0] slot_s;
    logic [SW-1:0]         src_slot;
    logic signed [CSW-1:0] col_s;
    logic [CW-1:0]         src_col;
    logic [AW-1:0]         rd_addr, wr_addr;

    // clamp the register values into range
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = WW'(1);
        else if (image_width_reg > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width_reg);

        if (image_height_reg == '0)
            h_eff = CFG_W'(1);
        else if (image_height_reg > MAX_HEIGHT)
            h_eff = CFG_W'(MAX_HEIGHT);
        else
            h_eff = image_height_reg;

        if (kernel_width_reg == '0)
            kw_eff = KWW'(1);
        else if (kernel_width_reg > MAX_KERNEL_W)
            kw_eff = KWW'(MAX_KERNEL_W);
        else
            kw_eff = KWW'(kernel_width_reg);

        if (kernel_height_reg == '0)
            kh_eff = KHW'(1);
        else if (kernel_height_reg > MAX_KERNEL_H)
            kh_eff = KHW'(MAX_KERNEL_H);
        else
            kh_eff = KHW'(kernel_height_reg);
    end

    // frame size, lag and the emit test
    always_comb
    begin
        kw_half    = kw_eff >> 1;
        kh_half    = kh_eff >> 1;
        total      = TW'(w_eff) * TW'(h_eff);
        lag        = TW'(kh_half) * TW'(w_eff) + TW'(kw_half);
        ahead      = {1'b0, out_cnt_reg} + {1'b0, lag};
        can_store  = in_cnt_reg < total;
        frame_done = (out_cnt_reg + TW'(1)) == total;
    end

    assign status.emit     = (out_cnt_reg < total) &&
                             (!can_store || ({1'b0, in_cnt_reg} > ahead));
    assign status.tap_last = (tap_x_reg == kw_eff - KWW'(1)) &&
                             (tap_y_reg == kh_eff - KHW'(1));
    assign status.out_busy = out_valid_reg && !out_ready;

    // source row, clamped, and its ring slot
    always_comb
    begin
        row_s = $signed(RSW'(out_row_reg) + RSW'(tap_y_reg) - RSW'(kh_half));
        if (row_s < 0)
            src_row = '0;
        else if (row_s > $signed(RSW'(h_eff) - RSW'(1)))
            src_row = ROW_W'(h_eff - CFG_W'(1));
        else
            src_row = row_s[ROW_W-1:0];

        row_off = $signed(RSW'(src_row) - RSW'(out_row_reg));
        slot_s  = $signed(OSW'(out_slot_reg)) + $signed(OSW'(row_off));
        if (slot_s < 0)
            slot_s = slot_s + $signed(OSW'(RING));
        else if (slot_s >= $signed(OSW'(RING)))
            slot_s = slot_s - $signed(OSW'(RING));
        src_slot = slot_s[SW-1:0];

        col_s = $signed(CSW'(out_col_reg) + CSW'(tap_x_reg) - CSW'(kw_half));
        if (col_s < 0)
            src_col = '0;
        else if (col_s > $signed(CSW'(w_eff) - CSW'(1)))
            src_col = CW'(w_eff - WW'(1));
        else
            src_col = col_s[CW-1:0];

        rd_addr = AW'(src_slot) * AW'(MAX_WIDTH) + AW'(src_col);
        wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            kernel_width_reg  <= RST_KERNEL_WIDTH;
            kernel_height_reg <= RST_KERNEL_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[KCFG_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[KCFG_W-1:0];
                default:           image_width_reg   <= image_width_reg;
            endcase
        end
    end

    // kernel table write and tap read
    always_ff @(posedge clk)
    begin
        if (cmd.load_coef && (coef_index < CDEPTH))
            coef_mem[CIW'(coef_index)] <= coef_value;
        if (cmd.tap_step)
            rd_coef_reg <= coef_mem[coef_idx_reg];
    end

    // line ring write and tap read
    always_ff @(posedge clk)
    begin
        if (cmd.store_pix && can_store)
            line_mem[wr_addr] <= {pix_c2, pix_c1, pix_c0};
        if (cmd.tap_step)
            rd_pix_reg <= line_mem[rd_addr];
    end

    // frame counters and positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg   <= '0;
            out_cnt_reg  <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else if (cfg_we || (cmd.out_load && frame_done))
        begin
            in_cnt_reg   <= '0;
            out_cnt_reg  <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            if (cmd.store_pix && can_store)
            begin
                in_cnt_reg <= in_cnt_reg + TW'(1);
                if ((WW'(in_col_reg) + WW'(1)) == w_eff)
                begin
                    in_col_reg  <= '0;
                    in_slot_reg <= (in_slot_reg == SW'(RING - 1)) ? '0
                                                                  : in_slot_reg + SW'(1);
                end
                else
                    in_col_reg <= in_col_reg + CW'(1);
            end
            if (cmd.out_load)
            begin
                out_cnt_reg <= out_cnt_reg + TW'(1);
                if ((WW'(out_col_reg) + WW'(1)) == w_eff)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + ROW_W'(1);
                    out_slot_reg <= (out_slot_reg == SW'(RING - 1)) ? '0
                                                                    : out_slot_reg + SW'(1);
                end
                else
                    out_col_reg <= out_col_reg + CW'(1);
            end
        end
    end

    // tap walk, row-major through the kernel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_x_reg    <= '0;
            tap_y_reg    <= '0;
            coef_idx_reg <= '0;
        end
        else if (cmd.acc_clear)
        begin
            tap_x_reg    <= '0;
            tap_y_reg    <= '0;
            coef_idx_reg <= '0;
        end
        else if (cmd.tap_step)
        begin
            coef_idx_reg <= coef_idx_reg + CIW'(1);
            if (tap_x_reg == kw_eff - KWW'(1))
            begin
                tap_x_reg <= '0;
                tap_y_reg <= tap_y_reg + KHW'(1);
            end
            else
                tap_x_reg <= tap_x_reg + KWW'(1);
        end
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.tap_step;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // products, one multiplier per channel
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prod0_reg <= PW'(rd_pix_reg[PIX_W-1:0]) * PW'(rd_coef_reg);
            prod1_reg <= PW'(rd_pix_reg[2*PIX_W-1:PIX_W]) * PW'(rd_coef_reg);
            prod2_reg <= PW'(rd_pix_reg[3*PIX_W-1:2*PIX_W]) * PW'(rd_coef_reg);
        end
    end

    // accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
        begin
            acc0_reg <= '0;
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc0_reg <= acc0_reg + ACW'(prod0_reg);
            acc1_reg <= acc1_reg + ACW'(prod1_reg);
            acc2_reg <= acc2_reg + ACW'(prod2_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_c0_reg   <= sat_pix(acc0_reg);
            out_c1_reg   <= sat_pix(acc1_reg);
            out_c2_reg   <= sat_pix(acc2_reg);
            out_last_reg <= frame_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_c0    = out_c0_reg;
    assign out_c1    = out_c1_reg;
    assign out_c2    = out_c2_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/kcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// kcr_ctrl
// Sequencer: takes a request, decides whether a result is due, walks the
// kernel taps and hands the sum to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcr_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [kcr_pkg::OP_W-1:0]  op,
    output logic                           in_ready,
    input  wire kcr_pkg::status_t          status,
    output kcr_pkg::cmd_t                  cmd
);
    import kcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_TAPS,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       ready_reg;
    logic [1:0] drain_reg, drain_next;
    logic       accept;

    assign accept   = in_valid && ready_reg;
    assign in_ready = ready_reg;

    // commands
    always_comb
    begin
        cmd.load_coef = accept && (op == OP_COEF);
        cmd.store_pix = accept && (op == OP_PIX);
        cmd.acc_clear = (state_reg == ST_DECIDE) && status.emit;
        cmd.tap_step  = (state_reg == ST_TAPS);
        cmd.out_load  = (state_reg == ST_EMIT) && !status.out_busy;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && ((op == OP_PIX) || (op == OP_FLUSH)))
                    state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = status.emit ? ST_TAPS : ST_IDLE;
            ST_TAPS:
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
            ST_DRAIN:
            begin
                // read, multiply and accumulate stages still in flight
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd2)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
                if (!status.out_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/kernel_convolution_replicate_edge_core.sv -----
// Flow: a pixel or flush request that releases a result goes through decide, the tap walk
//   over kw*kh taps (kw, kh the kernel size in use), drain and emit, which waits out an
//   output stall before loading the output register. Throughput: one per cycle for
//   coefficient loads and ignored ops; a pixel or flush request is worked to the end before
//   the next is taken, paced by the shared multiply-accumulate per channel walking the taps.
// Reset: rst_n asynchronous, active low; registers to 640, 480, 9, 9, counters to zero.
// ----------------------------------------------------------------------------
// kernel_convolution_replicate_edge_core
// Streaming 2-D convolution of three colour channels with replicated
// borders, loaded unsigned Q2.14 kernel, saturating output, alpha fixed.
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_convolution_replicate_edge_core #(
    parameter int MAX_WIDTH      = kcr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL_W   = kcr_pkg::DEF_MAX_KERNEL_W,
    parameter int MAX_KERNEL_H   = kcr_pkg::DEF_MAX_KERNEL_H,
    parameter int COEF_FRAC_BITS = kcr_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    kcr_in_if.sink                            in_ch,
    kcr_out_if.source                         out_ch,
    input  wire logic                         cfg_we,
    input  wire logic [kcr_pkg::CFGIX_W-1:0]  cfg_index,
    input  wire logic [kcr_pkg::CFG_W-1:0]    cfg_data
);
    import kcr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    kcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .op       (in_ch.op),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic
    kcr_datapath #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_KERNEL_W   (MAX_KERNEL_W),
        .MAX_KERNEL_H   (MAX_KERNEL_H),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .coef_index (in_ch.coef_index),
        .coef_value (in_ch.coef_value),
        .pix_c0     (in_ch.pix_c0),
        .pix_c1     (in_ch.pix_c1),
        .pix_c2     (in_ch.pix_c2),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_c0     (out_ch.out_c0),
        .out_c1     (out_ch.out_c1),
        .out_c2     (out_ch.out_c2),
        .out_last   (out_ch.last_of_frame)
    );

    // alpha is constant
    assign out_ch.out_alpha = ALPHA;

endmodule

`default_nettype wire

// ----- hdl/kcr_checker.sv -----
// ----------------------------------------------------------------------------
// kcr_checker
// Port-level checks on the convolution core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kcr_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic [kcr_pkg::OP_W-1:0]  in_op,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [7:0]                out_c0,
    input wire logic [7:0]                out_c1,
    input wire logic [7:0]                out_c2,
    input wire logic [7:0]                out_alpha,
    input wire logic                      last_of_frame
);
    import kcr_pkg::*;

    // alpha fixed on every result
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_alpha == ALPHA)
        else $error("alpha not opaque");

    // a pixel or flush request holds the input off while it is worked
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ((in_op == OP_PIX) || (in_op == OP_FLUSH)) |=> !in_ready)
        else $error("request taken while busy");

    // stalled result held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_c0, out_c1, out_c2, last_of_frame}))
        else $error("result changed under stall");

endmodule

bind kernel_convolution_replicate_edge_core kcr_checker u_kcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_op         (in_ch.op),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_c0        (out_ch.out_c0),
    .out_c1        (out_ch.out_c1),
    .out_c2        (out_ch.out_c2),
    .out_alpha     (out_ch.out_alpha),
    .last_of_frame (out_ch.last_of_frame)
);

`default_nettype wire

// ----- tb/sv/kernel_convolution_replicate_edge_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_convolution_replicate_edge_core_test
// Self-checking bench for the replicate-border convolution core. A built-in
// line store and kernel table predict every filtered pixel. Directed frames
// cover the register extremes. Random frames follow with noise requests and
// bursty stalls on both channels.
// ----------------------------------------------------------------------------
module kernel_convolution_replicate_edge_core_test;

    import kcr_pkg::*;

    // unused operation code, ignored by the core
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RING_ROWS  = 20;
    localparam int LINE_MAX   = 2048;
    localparam int TAPS       = 165;
    localparam int FRAC_BITS  = 14;
    localparam int KW_MAX     = 15;
    localparam int KH_MAX     = 11;

    typedef struct {
        logic [PIX_W-1:0] c0;
        logic [PIX_W-1:0] c1;
        logic [PIX_W-1:0] c2;
        logic             last;
    } filtered_pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFGIX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    kcr_in_if  in_ch ();
    kcr_out_if out_ch ();

    kernel_convolution_replicate_edge_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    bit [23:0]       line_ring [0:RING_ROWS*LINE_MAX-1];
    bit [COEF_W-1:0] kernel_tab [0:TAPS-1];
    int unsigned     pix_in_count;
    int unsigned     pix_out_count;
    int unsigned     img_w_reg, img_h_reg, ker_w_reg, ker_h_reg;

    filtered_pixel_t filtered_q [$];

    int mismatches;
    int requests_sent;
    bit quiet;
    bit hold_off_req;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned sat_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned eff_w();
        return sat_size(img_w_reg, LINE_MAX);
    endfunction

    function automatic int unsigned eff_h();
        return sat_size(img_h_reg, MAX_HEIGHT);
    endfunction

    function automatic int unsigned eff_kw();
        return sat_size(ker_w_reg, KW_MAX);
    endfunction

    function automatic int unsigned eff_kh();
        return sat_size(ker_h_reg, KH_MAX);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        return PIX_W'($urandom);
    endfunction

    // predicts the filtered pixel, if any, released by one request
    function automatic void convolve_request(logic [OP_W-1:0] op, logic [CIDX_W-1:0] idx,
                                             logic [COEF_W-1:0] val, logic [PIX_W-1:0] p0,
                                             logic [PIX_W-1:0] p1, logic [PIX_W-1:0] p2);
        int unsigned w, h, kw, kh, total, lag, row, col, slot;
        int sr, sc;
        longint unsigned acc [3];
        longint unsigned shifted;
        bit [23:0] src;
        filtered_pixel_t res;
        w = eff_w();
        h = eff_h();
        kw = eff_kw();
        kh = eff_kh();
        total = w * h;
        lag = (kh / 2) * w + kw / 2;
        if (op == OP_COEF)
        begin
            if (idx < TAPS) kernel_tab[idx] = val;
            return;
        end
        if (op != OP_PIX && op != OP_FLUSH) return;
        if (op == OP_PIX && pix_in_count < total)
        begin
            slot = ((pix_in_count / w) % RING_ROWS) * LINE_MAX + pix_in_count % w;
            line_ring[slot] = {p2, p1, p0};
            pix_in_count++;
        end
        if (pix_out_count >= total) return;
        if (!(pix_in_count >= total || pix_in_count > pix_out_count + lag)) return;
        row = pix_out_count / w;
        col = pix_out_count % w;
        acc = '{0, 0, 0};
        for (int y = 0; y < kh; y++)
        begin
            sr = int'(row) + y - int'(kh / 2);
            if (sr < 0) sr = 0;
            if (sr > int'(h) - 1) sr = int'(h) - 1;
            for (int x = 0; x < kw; x++)
            begin
                sc = int'(col) + x - int'(kw / 2);
                if (sc < 0) sc = 0;
                if (sc > int'(w) - 1) sc = int'(w) - 1;
                src = line_ring[(sr % RING_ROWS) * LINE_MAX + sc];
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(src[ch*8 +: 8]) * kernel_tab[y * kw + x];
            end
        end
        pix_out_count++;
        res.last = 1'b0;
        if (pix_out_count == total)
        begin
            res.last = 1'b1;
            pix_in_count = 0;
            pix_out_count = 0;
        end
        shifted = acc[0] >> FRAC_BITS;
        res.c0 = (shifted > 255) ? PIX_MAX : shifted[7:0];
        shifted = acc[1] >> FRAC_BITS;
        res.c1 = (shifted > 255) ? PIX_MAX : shifted[7:0];
        shifted = acc[2] >> FRAC_BITS;
        res.c2 = (shifted > 255) ? PIX_MAX : shifted[7:0];
        filtered_q.push_back(res);
    endfunction

    // result sink with bursty stalls and a long hold-off on demand
    int stall_left;
    int hold_left;
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_left = 600;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        filtered_pixel_t exp_px;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (filtered_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel c0=%0d c1=%0d c2=%0d last=%0b",
                             out_ch.out_c0, out_ch.out_c1, out_ch.out_c2,
                             out_ch.last_of_frame);
            end
            else
            begin
                exp_px = filtered_q.pop_front();
                if (out_ch.out_c0 !== exp_px.c0 || out_ch.out_c1 !== exp_px.c1 ||
                    out_ch.out_c2 !== exp_px.c2 || out_ch.out_alpha !== ALPHA ||
                    out_ch.last_of_frame !== exp_px.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                                 exp_px.c0, exp_px.c1, exp_px.c2, ALPHA, exp_px.last,
                                 out_ch.out_c0, out_ch.out_c1, out_ch.out_c2,
                                 out_ch.out_alpha, out_ch.last_of_frame);
                end
            end
        end
    end

    // one request; valid stays high afterwards until a gap before the next request or the next wait lowers it
    task automatic send_req(logic [OP_W-1:0] op, logic [CIDX_W-1:0] idx,
                            logic [COEF_W-1:0] val, logic [PIX_W-1:0] p0,
                            logic [PIX_W-1:0] p1, logic [PIX_W-1:0] p2);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.coef_index <= idx;
        in_ch.coef_value <= val;
        in_ch.pix_c0     <= p0;
        in_ch.pix_c1     <= p1;
        in_ch.pix_c2     <= p2;
        do @(posedge clk); while (!in_ch.ready);
        convolve_request(op, idx, val, p0, p1, p2);
        requests_sent++;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                              logic [PIX_W-1:0] p2);
        send_req(OP_PIX, CIDX_W'($urandom), COEF_W'($urandom), p0, p1, p2);
    endtask

    task automatic send_flush();
        send_req(OP_FLUSH, CIDX_W'($urandom), COEF_W'($urandom), rand_pix(), rand_pix(),
                 rand_pix());
    endtask

    task automatic send_coef(int unsigned idx, logic [COEF_W-1:0] val);
        send_req(OP_COEF, idx[CIDX_W-1:0], val, rand_pix(), rand_pix(), rand_pix());
    endtask

    // a run of random pixels that may stop short of the frame end
    task automatic send_pixels(int n);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pix(), rand_pix(), rand_pix());
    endtask

    // drain all results, then let the last tap walk finish
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (eff_kw() * eff_kh() + 20) @(posedge clk);
    endtask

    // writes all four registers; any write restarts the frame
    task automatic write_regs(int unsigned w, int unsigned h, int unsigned kw,
                              int unsigned kh);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= w[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= h[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_KERNEL_WIDTH;
        cfg_data <= CFG_W'(kw[KCFG_W-1:0]);
        @(posedge clk);
        cfg_index <= REG_KERNEL_HEIGHT;
        cfg_data <= CFG_W'(kh[KCFG_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
        img_w_reg = w[CFG_W-1:0];
        img_h_reg = h[CFG_W-1:0];
        ker_w_reg = kw[KCFG_W-1:0];
        ker_h_reg = kh[KCFG_W-1:0];
        pix_in_count = 0;
        pix_out_count = 0;
    endtask

    // a whole frame of random pixels with optional noise, then the drain
    task automatic run_frame(bit noisy);
        int unsigned total;
        total = eff_w() * eff_h();
        for (int unsigned i = 0; i < total; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_req(OP_SPARE, CIDX_W'($urandom), COEF_W'($urandom),
                                rand_pix(), rand_pix(), rand_pix());
                    1: send_coef($urandom_range(TAPS, 255), COEF_W'($urandom));
                    default: send_coef($urandom_range(0, TAPS - 1),
                                       COEF_W'($urandom_range(0, 4000)));
                endcase
            end
            send_pixel(rand_pix(), rand_pix(), rand_pix());
        end
        // drain; a pixel past the frame end acts as a flush
        while (pix_in_count != 0)
        begin
            if ($urandom_range(0, 3) == 0) send_pixel(rand_pix(), rand_pix(), rand_pix());
            else send_flush();
        end
        if ($urandom_range(0, 3) == 0) send_flush();
    endtask

    task automatic test_kernel_table();
        send_coef(0, 16'd0);
        send_coef(1, 16'hFFFF);
        for (int i = 2; i < TAPS; i++)
            send_coef(i, COEF_W'($urandom_range(0, 3000)));
        // out-of-table indexes and the spare op are ignored
        send_coef(TAPS, 16'h1234);
        send_coef(255, 16'hFFFF);
        send_req(OP_SPARE, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_small_frame();
        write_regs(4, 3, 3, 3);
        send_coef(4, 16'd16384);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'h0F);
        send_pixel(8'h55, 8'hAA, 8'hF0);
        for (int i = 0; i < 8; i++)
            send_pixel(rand_pix(), rand_pix(), rand_pix());
        send_pixel(8'h01, 8'h80, 8'hFE);
        send_flush();
        while (pix_in_count != 0) send_flush();
        send_flush();
    endtask

    task automatic test_saturation();
        write_regs(3, 2, 3, 2);
        for (int i = 0; i < 6; i++) send_coef(i, 16'hFFFF);
        run_frame(1'b0);
        for (int i = 0; i < 6; i++) send_coef(i, COEF_W'($urandom_range(0, 3000)));
    endtask

    task automatic test_register_extremes();
        write_regs(0, 0, 0, 0);
        run_frame(1'b0);
        // oversized and maximal registers, most frames cut short by the next write
        write_regs(4095, 1, 15, 1);
        send_pixels(40);
        write_regs(1, 4095, 1, 15);
        send_pixels(40);
        write_regs(5, 4, 15, 11);
        run_frame(1'b0);
        write_regs(2048, 1, 3, 1);
        send_pixels(40);
    endtask

    task automatic test_restart_mid_frame();
        write_regs(6, 5, 3, 5);
        for (int i = 0; i < 17; i++) send_pixel(rand_pix(), rand_pix(), rand_pix());
        write_regs(6, 5, 3, 5);
        run_frame(1'b0);
    endtask

    task automatic test_output_backpressure();
        write_regs(8, 6, 3, 3);
        hold_off_req = 1'b1;
        run_frame(1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned w, h;
        while (requests_sent < 1550)
        begin
            if (requests_sent > 1300) quiet = 1'b1;
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            h = $urandom_range(0, 10);
            write_regs(w, h, $urandom_range(0, 15), $urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < 8; i++)
                    send_coef($urandom_range(0, TAPS - 1),
                              ($urandom_range(0, 5) == 0) ? 16'hFFFF
                                                          : COEF_W'($urandom_range(0, 4000)));
            run_frame(1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_FLUSH;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.pix_c0 = '0;
        in_ch.pix_c1 = '0;
        in_ch.pix_c2 = '0;
        out_ch.ready = 1'b0;
        quiet = 1'b0;
        hold_off_req = 1'b0;
        stall_left = 0;
        hold_left = 0;
        mismatches = 0;
        requests_sent = 0;
        pix_in_count = 0;
        pix_out_count = 0;
        img_w_reg = RST_IMAGE_WIDTH;
        img_h_reg = RST_IMAGE_HEIGHT;
        ker_w_reg = RST_KERNEL_WIDTH;
        ker_h_reg = RST_KERNEL_HEIGHT;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_kernel_table();
        test_small_frame();
        test_saturation();
        test_register_extremes();
        test_restart_mid_frame();
        test_output_backpressure();
        test_random_frames();

        wait_idle();
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
